// ===== sv/oes_pkg.sv =====
`default_nettype none

package oes_pkg;

  localparam int FRAC_BITS = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divider widths
  localparam int DIVIDEND_W = 55;
  localparam int DIVISOR_W  = 40;
  localparam int QUOT_W     = 38;
  localparam int DSH_W      = 57;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_ALPHA = 6'd17;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_SPEED = 6'd37;

  localparam logic [19:0] US_PER_S     = 20'd1000000;
  localparam logic [19:0] TWO_PI_Q16   = 20'd411775;
  localparam logic [16:0] ALPHA_ONE    = 17'd65536;
  localparam logic [15:0] SPEED_CUTOFF = 16'd256;
  localparam logic [15:0] CUTOFF_MAX   = 16'hFFFF;
  localparam logic [55:0] DEN_BIAS     = 56'd16777216000000;

  localparam logic [15:0] MIN_CUTOFF_RST = 16'd256;
  localparam logic [15:0] SPEED_GAIN_RST = 16'd0;
  localparam logic [16:0] JUMP_THR_RST   = 17'd3932;

  typedef enum logic [1:0] {
    CFG_MIN_CUTOFF = 2'd0,
    CFG_SPEED_GAIN = 2'd1,
    CFG_JUMP_THR   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    DIV_ALPHA = 1'b0,
    DIV_SPEED = 1'b1
  } div_mode_t;

  typedef struct packed {
    logic      start;
    div_mode_t mode;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef enum logic [21:0] {
    ST_IDLE    = 22'h000001,
    ST_J_U     = 22'h000002,
    ST_J_V     = 22'h000004,
    ST_J_T     = 22'h000008,
    ST_J_CMP   = 22'h000010,
    ST_DECIDE  = 22'h000020,
    ST_A_CD    = 22'h000040,
    ST_A_P0    = 22'h000080,
    ST_A_P1    = 22'h000100,
    ST_A_NUM   = 22'h000200,
    ST_A_DEN   = 22'h000400,
    ST_A_DIV   = 22'h000800,
    ST_SP_MUL  = 22'h001000,
    ST_SP_DIVS = 22'h002000,
    ST_SP_WAIT = 22'h004000,
    ST_SP_BL   = 22'h008000,
    ST_SP_SAT  = 22'h010000,
    ST_CU_MUL  = 22'h020000,
    ST_CU_ADD  = 22'h040000,
    ST_ES_MUL  = 22'h080000,
    ST_ES_UPD  = 22'h100000,
    ST_FIN     = 22'h200000
  } state_t;

endpackage

`default_nettype wire

// ===== sv/oes_ifs.sv =====
`default_nettype none

interface oes_in_if;
  logic               valid;
  logic               ready;
  logic               hovering;
  logic signed [17:0] raw_u;
  logic signed [17:0] raw_v;
  logic        [19:0] delta_time;
  modport source (output valid, hovering, raw_u, raw_v, delta_time, input ready);
  modport sink   (input valid, hovering, raw_u, raw_v, delta_time, output ready);
endinterface

interface oes_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [17:0] smooth_u;
  logic signed [17:0] smooth_v;
  modport source (output valid, valid_res, smooth_u, smooth_v, input ready);
  modport sink   (input valid, valid_res, smooth_u, smooth_v, output ready);
endinterface

interface oes_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/pointer_uv_one_euro_smoother_unit.sv =====
`default_nettype none

// A non-hovering transaction goes straight to the result; a restart (first sample, jump, zero
//   dt or zero min_cutoff) passes the raw sample through; a filtered one runs both axes.
// One transaction at a time; a filtered one is bounded by the shared divider: the 38-step
//   speed divide twice and the 18-step alpha divide three times.
// Reset: rst_n is synchronous and active low; it clears the filter state and loads register
//   defaults (min_cutoff 256, speed_gain 0, jump_threshold 3932).
module pointer_uv_one_euro_smoother_unit import oes_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  oes_in_if.sink     in_ch,
  oes_out_if.source  out_ch,
  oes_cfg_if.sink    cfg_ch
);

  // sequencer
  state_t state_r, state_nxt;

  // captured transaction
  logic               hov_r, hov_nxt;
  logic signed [17:0] ru_r, ru_nxt, rv_r, rv_nxt;
  logic        [19:0] dt_r, dt_nxt;

  // filter state
  logic               primed_r, primed_nxt;
  logic signed [17:0] est_u_r, est_u_nxt, est_v_r, est_v_nxt;
  logic signed [31:0] spd_u_r, spd_u_nxt, spd_v_r, spd_v_nxt;

  // configuration
  logic [15:0] mc_r, sg_r;
  logic [16:0] thr_r;

  // working registers
  logic [MUL_P_W-1:0] prod_r, prod_nxt;
  logic [37:0]        acc_r, acc_nxt;
  logic [17:0]        cdt_hi_r, cdt_hi_nxt;
  logic [36:0]        p0_r, p0_nxt;
  logic [DIVIDEND_W-1:0] num_r, num_nxt;
  logic [15:0]        cut_r, cut_nxt;
  logic               asel_r, asel_nxt;   // 0: speed alpha, 1: position alpha
  logic [16:0]        ad_r, ad_nxt, al_r, al_nxt;
  logic               axis_r, axis_nxt;
  logic               dneg_r, dneg_nxt;
  logic [32:0]        dmag_r, dmag_nxt;
  logic [31:0]        absp_r, absp_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_res_r, out_res_nxt;
  logic signed [17:0] out_u_r, out_u_nxt, out_v_r, out_v_nxt;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;

  // shared divider
  div_ctl_t              div_ctl;
  div_sts_t              div_sts;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [QUOT_W-1:0]     div_quot;

  // per-axis combinational helpers
  logic signed [18:0] du, dv, diff_ax;
  logic [18:0]        du_mag, dv_mag, diff_mag;
  logic               diff_neg;
  logic signed [17:0] est_ax;
  logic signed [31:0] spd_ax;
  logic               in_acc, out_acc;

  logic [55:0]        den_sum;
  logic [31:0]        dx;
  logic signed [32:0] dsig;
  logic [50:0]        rnd_s;
  logic signed [35:0] sp_sum;
  logic signed [31:0] sp_sat;
  logic [28:0]        cut_sum;
  logic [36:0]        rnd_e;
  logic [19:0]        est_new;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_valid_r && out_ch.ready;

  assign du       = {ru_r[17], ru_r} - {est_u_r[17], est_u_r};
  assign dv       = {rv_r[17], rv_r} - {est_v_r[17], est_v_r};
  assign du_mag   = du[18] ? 19'(-du) : 19'(du);
  assign dv_mag   = dv[18] ? 19'(-dv) : 19'(dv);
  assign est_ax   = axis_r ? est_v_r : est_u_r;
  assign spd_ax   = axis_r ? spd_v_r : spd_u_r;
  assign diff_ax  = axis_r ? dv : du;
  assign diff_mag = axis_r ? dv_mag : du_mag;
  assign diff_neg = diff_ax[18];

  assign prod_nxt = mul_a * mul_b;

  // den = (num + 10^6 * 2^24) / 2^16
  assign den_sum = {1'b0, num_r} + DEN_BIAS;

  // raw speed, saturated to 32 bits
  always_comb begin
    if (!diff_neg) begin
      dx = (div_quot > 38'h007FFFFFFF) ? 32'h7FFFFFFF : div_quot[31:0];
    end else begin
      dx = (div_quot > 38'h0080000000) ? 32'h80000000 : 32'(-div_quot[31:0]);
    end
  end
  assign dsig = {dx[31], dx} - {spd_ax[31], spd_ax};

  // speed blend: round half away from zero, then saturate
  assign rnd_s  = {1'b0, prod_r[49:0]} + 51'd32768;
  assign sp_sum = dneg_r ? ({{4{spd_ax[31]}}, spd_ax} - {1'b0, rnd_s[50:16]})
                         : ({{4{spd_ax[31]}}, spd_ax} + {1'b0, rnd_s[50:16]});
  always_comb begin
    if (sp_sum > 36'sd2147483647) begin
      sp_sat = 32'sh7FFFFFFF;
    end else if (sp_sum < -36'sd2147483648) begin
      sp_sat = 32'sh80000000;
    end else begin
      sp_sat = sp_sum[31:0];
    end
  end

  // cutoff = min_cutoff + gain*|speed| / 2^(FRAC_BITS+4)
  assign cut_sum = {13'd0, mc_r} + 29'(prod_r >> (FRAC_BITS + 4));

  // position blend
  assign rnd_e   = {1'b0, prod_r[35:0]} + 37'd32768;
  assign est_new = diff_neg ? ({{2{est_ax[17]}}, est_ax} - rnd_e[35:16])
                            : ({{2{est_ax[17]}}, est_ax} + rnd_e[35:16]);

  always_comb begin
    state_nxt     = state_r;
    hov_nxt       = hov_r;
    ru_nxt        = ru_r;
    rv_nxt        = rv_r;
    dt_nxt        = dt_r;
    primed_nxt    = primed_r;
    est_u_nxt     = est_u_r;
    est_v_nxt     = est_v_r;
    spd_u_nxt     = spd_u_r;
    spd_v_nxt     = spd_v_r;
    acc_nxt       = acc_r;
    cdt_hi_nxt    = cdt_hi_r;
    p0_nxt        = p0_r;
    num_nxt       = num_r;
    cut_nxt       = cut_r;
    asel_nxt      = asel_r;
    ad_nxt        = ad_r;
    al_nxt        = al_r;
    axis_nxt      = axis_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    absp_nxt      = absp_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    out_res_nxt   = out_res_r;
    out_u_nxt     = out_u_r;
    out_v_nxt     = out_v_r;
    mul_a         = '0;
    mul_b         = '0;
    div_ctl.start = 1'b0;
    div_ctl.mode  = DIV_ALPHA;
    div_dividend  = {1'b0, prod_r};
    div_divisor   = {20'd0, dt_r};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hov_nxt = in_ch.hovering;
          ru_nxt  = in_ch.raw_u;
          rv_nxt  = in_ch.raw_v;
          dt_nxt  = in_ch.delta_time;
          if (!in_ch.hovering) begin
            // drop all state; the result reports not valid with zeros
            primed_nxt = 1'b0;
            est_u_nxt  = '0;
            est_v_nxt  = '0;
            spd_u_nxt  = '0;
            spd_v_nxt  = '0;
            state_nxt  = ST_FIN;
          end else if (primed_r) begin
            state_nxt = ST_J_U;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      // jump test: du^2 + dv^2 against threshold^2
      ST_J_U: begin
        mul_a     = 34'(du_mag);
        mul_b     = 20'(du_mag);
        state_nxt = ST_J_V;
      end
      ST_J_V: begin
        acc_nxt   = prod_r[37:0];
        mul_a     = 34'(dv_mag);
        mul_b     = 20'(dv_mag);
        state_nxt = ST_J_T;
      end
      ST_J_T: begin
        acc_nxt   = acc_r + prod_r[37:0];
        mul_a     = 34'(thr_r);
        mul_b     = 20'(thr_r);
        state_nxt = ST_J_CMP;
      end
      ST_J_CMP: begin
        if (acc_r >= prod_r[37:0]) begin
          primed_nxt = 1'b0;
          est_u_nxt  = '0;
          est_v_nxt  = '0;
          spd_u_nxt  = '0;
          spd_v_nxt  = '0;
        end
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!primed_r || (dt_r == '0) || (mc_r == '0)) begin
          // restart: pass the raw sample through
          primed_nxt = 1'b1;
          est_u_nxt  = ru_r;
          est_v_nxt  = rv_r;
          spd_u_nxt  = '0;
          spd_v_nxt  = '0;
          state_nxt  = ST_FIN;
        end else begin
          cut_nxt   = SPEED_CUTOFF;
          asel_nxt  = 1'b0;
          axis_nxt  = 1'b0;
          state_nxt = ST_A_CD;
        end
      end
      // alpha = num / ((num + 10^6*2^24) / 2^16), num = cutoff*dt*2pi
      ST_A_CD: begin
        mul_a     = 34'(cut_r);
        mul_b     = dt_r;
        state_nxt = ST_A_P0;
      end
      ST_A_P0: begin
        cdt_hi_nxt = prod_r[35:18];
        mul_a      = 34'(prod_r[17:0]);
        mul_b      = TWO_PI_Q16;
        state_nxt  = ST_A_P1;
      end
      ST_A_P1: begin
        p0_nxt    = prod_r[36:0];
        mul_a     = 34'(cdt_hi_r);
        mul_b     = TWO_PI_Q16;
        state_nxt = ST_A_NUM;
      end
      ST_A_NUM: begin
        num_nxt   = {18'd0, p0_r} + {prod_r[36:0], 18'd0};
        state_nxt = ST_A_DEN;
      end
      ST_A_DEN: begin
        div_ctl.start = 1'b1;
        div_ctl.mode  = DIV_ALPHA;
        div_dividend  = num_r;
        div_divisor   = den_sum[55:16];
        state_nxt     = ST_A_DIV;
      end
      ST_A_DIV: begin
        if (div_sts.done) begin
          if (asel_r) begin
            al_nxt    = (div_quot > 38'(ALPHA_ONE)) ? ALPHA_ONE : div_quot[16:0];
            state_nxt = ST_ES_MUL;
          end else begin
            ad_nxt    = (div_quot > 38'(ALPHA_ONE)) ? ALPHA_ONE : div_quot[16:0];
            state_nxt = ST_SP_MUL;
          end
        end
      end
      // raw speed = |diff| * 10^6 / dt
      ST_SP_MUL: begin
        mul_a     = 34'(diff_mag);
        mul_b     = US_PER_S;
        state_nxt = ST_SP_DIVS;
      end
      ST_SP_DIVS: begin
        div_ctl.start = 1'b1;
        div_ctl.mode  = DIV_SPEED;
        state_nxt     = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        if (div_sts.done) begin
          dneg_nxt  = dsig[32];
          dmag_nxt  = dsig[32] ? 33'(-dsig) : 33'(dsig);
          state_nxt = ST_SP_BL;
        end
      end
      ST_SP_BL: begin
        mul_a     = 34'(dmag_r);
        mul_b     = 20'(ad_r);
        state_nxt = ST_SP_SAT;
      end
      ST_SP_SAT: begin
        if (axis_r) begin
          spd_v_nxt = sp_sat;
        end else begin
          spd_u_nxt = sp_sat;
        end
        absp_nxt  = sp_sat[31] ? 32'(-sp_sat) : 32'(sp_sat);
        state_nxt = ST_CU_MUL;
      end
      ST_CU_MUL: begin
        mul_a     = 34'(absp_r);
        mul_b     = 20'(sg_r);
        state_nxt = ST_CU_ADD;
      end
      ST_CU_ADD: begin
        cut_nxt   = (cut_sum > 29'(CUTOFF_MAX)) ? CUTOFF_MAX : cut_sum[15:0];
        asel_nxt  = 1'b1;
        state_nxt = ST_A_CD;
      end
      ST_ES_MUL: begin
        mul_a     = 34'(diff_mag);
        mul_b     = 20'(al_r);
        state_nxt = ST_ES_UPD;
      end
      ST_ES_UPD: begin
        if (axis_r) begin
          est_v_nxt = est_new[17:0];
          state_nxt = ST_FIN;
        end else begin
          est_u_nxt = est_new[17:0];
          axis_nxt  = 1'b1;
          asel_nxt  = 1'b0;
          state_nxt = ST_SP_MUL;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = hov_r;
          out_u_nxt     = est_u_r;
          out_v_nxt     = est_v_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      est_u_r     <= '0;
      est_v_r     <= '0;
      spd_u_r     <= '0;
      spd_v_r     <= '0;
      out_valid_r <= 1'b0;
      mc_r        <= MIN_CUTOFF_RST;
      sg_r        <= SPEED_GAIN_RST;
      thr_r       <= JUMP_THR_RST;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      est_u_r     <= est_u_nxt;
      est_v_r     <= est_v_nxt;
      spd_u_r     <= spd_u_nxt;
      spd_v_r     <= spd_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_MIN_CUTOFF: mc_r  <= cfg_ch.data[15:0];
          CFG_SPEED_GAIN: sg_r  <= cfg_ch.data[15:0];
          CFG_JUMP_THR:   thr_r <= cfg_ch.data;
          default: begin
            // ignore writes outside the register list
          end
        endcase
      end
    end
    hov_r    <= hov_nxt;
    ru_r     <= ru_nxt;
    rv_r     <= rv_nxt;
    dt_r     <= dt_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    cdt_hi_r <= cdt_hi_nxt;
    p0_r     <= p0_nxt;
    num_r    <= num_nxt;
    cut_r    <= cut_nxt;
    asel_r   <= asel_nxt;
    ad_r     <= ad_nxt;
    al_r     <= al_nxt;
    axis_r   <= axis_nxt;
    dneg_r   <= dneg_nxt;
    dmag_r   <= dmag_nxt;
    absp_r   <= absp_nxt;
    out_res_r <= out_res_nxt;
    out_u_r   <= out_u_nxt;
    out_v_r   <= out_v_nxt;
  end

  oes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_res_r;
  assign out_ch.smooth_u  = out_u_r;
  assign out_ch.smooth_v  = out_v_r;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r) |-> (out_u_r == '0) && (out_v_r == '0))
    else $error("result without valid_res carries non-zero coordinates");
  a_leave_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.hovering) |=> !primed_r && (est_u_r == '0) && (spd_v_r == '0))
    else $error("state not cleared after a non-hovering transaction");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");
  a_alpha_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ES_MUL) |-> (al_r <= ALPHA_ONE) && (ad_r <= ALPHA_ONE))
    else $error("alpha above one");
`endif

endmodule

`default_nettype wire

// ===== sv/oes_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module oes_div import oes_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire div_ctl_t              ctl,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output div_sts_t                   sts,
  output logic [QUOT_W-1:0]          quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0]     dsh_r, dsh_nxt;
  logic [QUOT_W-1:0]    quot_r, quot_nxt;
  logic [DSH_W-1:0]     rem_ext, rem_sub;
  logic                 fits;

  assign rem_ext = {{(DSH_W-DIVIDEND_W){1'b0}}, rem_r};
  assign rem_sub = rem_ext - dsh_r;
  assign fits    = rem_ext >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = dividend;
      quot_nxt = '0;
      if (ctl.mode == DIV_ALPHA) begin
        dsh_nxt = {divisor, 17'd0};
        cnt_nxt = DIV_LAST_ALPHA;
      end else begin
        dsh_nxt = {divisor[19:0], 37'd0};
        cnt_nxt = DIV_LAST_SPEED;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_sub[DIVIDEND_W-1:0];
      end
      quot_nxt = {quot_r[QUOT_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = quot_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a preceding busy run");
`endif

endmodule

`default_nettype wire
